// ----- design/agd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agd_pkg
// Types, constants and helpers shared by the group-wise dequantizer modules.
// ----------------------------------------------------------------------------
package agd_pkg;

  localparam int unsigned MAX_GROUPS        = 256;
  localparam int unsigned MAX_WORDS_PER_ROW = 512;
  localparam int unsigned GRP_W             = $clog2(MAX_GROUPS);

  // request kinds
  localparam logic ACT_TABLE = 1'b0;
  localparam logic ACT_WORD  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_CODE_WIDTH_MODE = 2'd0;
  localparam logic [1:0] REG_GRP_LEN         = 2'd1;
  localparam logic [1:0] REG_WORDS_PER_ROW   = 2'd2;

  localparam logic [12:0] GRP_LEN_RST       = 13'd64;
  localparam logic [9:0]  WORDS_PER_ROW_RST = 10'd512;

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

  typedef struct packed {
    logic        action;
    logic [31:0] packed_word;
    logic [7:0]  group_slot;
    logic [31:0] scale_bits;
    logic [31:0] bias_bits;
  } item_t;

  typedef struct packed {
    logic        code_width_mode;
    logic [12:0] grp_len;
    logic [9:0]  words_per_row;
    logic        config_error;
    logic        check_busy;
  } cfg_t;

  typedef struct packed {
    logic [11:0] column;
    logic        last_of_word;
    logic        row_end;
    logic        config_error;
  } lane_info_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] scale;
    logic [31:0] bias;
    lane_info_t  info;
  } lane_t;

  // index of the highest set bit, zero when none
  function automatic logic [4:0] msb_index32(input logic [31:0] v);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

// ----- design/agd_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agd_cfg
// Register file on the bus port plus a serial check of group size against
// the row length (restoring remainder, one quotient bit per cycle).
// ----------------------------------------------------------------------------
module agd_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output agd_pkg::cfg_t       cfg_o
);

  logic        mode_r;
  logic [12:0] gsize_r;
  logic [9:0]  wpr_r;
  logic        busy_r;
  logic [3:0]  idx_r;
  logic [12:0] rem_r;
  logic [12:0] quo_r;
  logic        err_r;

  logic        wr;
  logic [9:0]  row_words;
  logic [12:0] cols;
  logic [13:0] r2;
  logic        ge;
  logic [12:0] rem_nxt;
  logic [12:0] quo_nxt;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    if (wpr_r == 10'd0) row_words = 10'd1;
    else if (wpr_r > 10'(agd_pkg::MAX_WORDS_PER_ROW))
      row_words = 10'(agd_pkg::MAX_WORDS_PER_ROW);
    else row_words = wpr_r;
    cols    = mode_r ? {1'b0, row_words, 2'b00} : {row_words, 3'b000};
    r2      = {rem_r, cols[idx_r]};
    ge      = r2 >= {1'b0, gsize_r};
    rem_nxt = ge ? 13'(r2 - {1'b0, gsize_r}) : r2[12:0];
    quo_nxt = {quo_r[11:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      gsize_r <= agd_pkg::GRP_LEN_RST;
      wpr_r   <= agd_pkg::WORDS_PER_ROW_RST;
      busy_r  <= 1'b1;
      idx_r   <= 4'd12;
      rem_r   <= 13'd0;
      quo_r   <= 13'd0;
      err_r   <= 1'b0;
    end else if (wr) begin
      unique case (paddr[3:2])
        agd_pkg::REG_CODE_WIDTH_MODE: mode_r  <= pwdata[0];
        agd_pkg::REG_GRP_LEN:         gsize_r <= pwdata[12:0];
        agd_pkg::REG_WORDS_PER_ROW:   wpr_r   <= pwdata[9:0];
        default: ;
      endcase
      busy_r <= 1'b1;
      idx_r  <= 4'd12;
      rem_r  <= 13'd0;
      quo_r  <= 13'd0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (idx_r == 4'd0) begin
        busy_r <= 1'b0;
        err_r  <= (gsize_r == 13'd0) || (rem_nxt != 13'd0) ||
                  (quo_nxt > 13'(agd_pkg::MAX_GROUPS));
      end else begin
        idx_r <= idx_r - 4'd1;
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      agd_pkg::REG_CODE_WIDTH_MODE: prdata = {31'd0, mode_r};
      agd_pkg::REG_GRP_LEN:         prdata = {19'd0, gsize_r};
      agd_pkg::REG_WORDS_PER_ROW:   prdata = {22'd0, wpr_r};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg_o.code_width_mode = mode_r;
  assign cfg_o.grp_len         = gsize_r;
  assign cfg_o.words_per_row   = row_words;
  assign cfg_o.config_error    = err_r;
  assign cfg_o.check_busy      = busy_r;

endmodule

// ----- design/agd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agd_front
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module agd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  agd_pkg::item_t in_item,
  input  logic           hold,
  output logic           q_valid,
  output agd_pkg::item_t q_item,
  input  logic           q_pop
);

  agd_pkg::item_t slot_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     cnt_r;
  logic           push;

  assign in_stall = (cnt_r == 2'd2) | hold;
  assign push     = in_valid & ~in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push)  wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/agd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agd_back
// Executes queued requests: table writes, and one code lane per cycle of a
// packed word unless stalled, with the row counters and scale/bias reads.
// ----------------------------------------------------------------------------
module agd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  agd_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  agd_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           adv,
  output logic           lane_valid,
  output agd_pkg::lane_t lane
);

  logic [31:0] scale_mem [agd_pkg::MAX_GROUPS];
  logic [31:0] bias_mem  [agd_pkg::MAX_GROUPS];

  logic                      busy_r;
  logic [31:0]               word_r;
  logic [2:0]                lane_r;
  logic [8:0]                wcnt_r;
  logic [11:0]               col_r;
  logic [12:0]               cig_r;
  logic [agd_pkg::GRP_W-1:0] grp_r;

  logic                      s1_valid_r;
  logic [7:0]                s1_code_r;
  agd_pkg::lane_info_t       s1_info_r;
  logic [31:0]               s1_scale_r;
  logic [31:0]               s1_bias_r;

  logic        lane_last;
  logic        last_word;
  logic        issue;
  logic        tbl_wr;
  logic [12:0] gsize;
  logic [13:0] cig_inc;
  logic [7:0]  code;

  always_comb begin
    lane_last = cfg.code_width_mode ? (lane_r == 3'd3) : (lane_r == 3'd7);
    last_word = ({1'b0, wcnt_r} + 10'd1) >= cfg.words_per_row;
    issue     = busy_r & adv;
    q_pop     = q_valid & adv & (~busy_r | lane_last);
    tbl_wr    = q_pop & (q_item.action == agd_pkg::ACT_TABLE);
    gsize     = (cfg.grp_len == 13'd0) ? 13'd1 : cfg.grp_len;
    cig_inc   = {1'b0, cig_r} + 14'd1;
    code      = cfg.code_width_mode ? word_r[7:0] : {4'd0, word_r[3:0]};
  end

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      scale_mem[q_item.group_slot[agd_pkg::GRP_W-1:0]] <= q_item.scale_bits;
      bias_mem[q_item.group_slot[agd_pkg::GRP_W-1:0]]  <= q_item.bias_bits;
    end
  end

  // table read runs alongside the lane's sideband
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_scale_r             <= scale_mem[grp_r];
      s1_bias_r              <= bias_mem[grp_r];
      s1_code_r              <= code;
      s1_info_r.column       <= col_r;
      s1_info_r.last_of_word <= lane_last;
      s1_info_r.row_end      <= lane_last & last_word;
      s1_info_r.config_error <= cfg.config_error;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.action == agd_pkg::ACT_WORD) word_r <= q_item.packed_word;
    else if (issue) word_r <= cfg.code_width_mode ? (word_r >> 8) : (word_r >> 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      lane_r     <= 3'd0;
      wcnt_r     <= 9'd0;
      col_r      <= 12'd0;
      cig_r      <= 13'd0;
      grp_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (adv) s1_valid_r <= busy_r;
      if (issue) begin
        lane_r <= lane_r + 3'd1;
        if (lane_last) busy_r <= 1'b0;
        if (lane_last && last_word) begin
          wcnt_r <= 9'd0;
          col_r  <= 12'd0;
          cig_r  <= 13'd0;
          grp_r  <= '0;
        end else begin
          if (lane_last) wcnt_r <= wcnt_r + 9'd1;
          col_r <= col_r + 12'd1;
          if (cig_inc >= {1'b0, gsize}) begin
            cig_r <= 13'd0;
            grp_r <= grp_r + 1'b1;
          end else begin
            cig_r <= cig_inc[12:0];
          end
        end
      end
      if (q_pop && q_item.action == agd_pkg::ACT_WORD) begin
        busy_r <= 1'b1;
        lane_r <= 3'd0;
      end
    end
  end

  assign lane_valid = s1_valid_r;
  assign lane.code  = s1_code_r;
  assign lane.scale = s1_scale_r;
  assign lane.bias  = s1_bias_r;
  assign lane.info  = s1_info_r;

endmodule

// ----- design/agd_fpu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agd_fpu
// Pipelined fp32 scale*code then +bias, each rounded to nearest even,
// ending in the result register.
// ----------------------------------------------------------------------------
module agd_fpu (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                lane_valid,
  input  agd_pkg::lane_t      lane,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_value,
  output agd_pkg::lane_info_t out_info
);

  // multiply stage 1
  logic m1_v_r, m1_sign_r, m1_spec_r;
  logic [31:0] m1_p_r, m1_spec_bits_r, m1_bias_r;
  logic [7:0]  m1_e_r;
  agd_pkg::lane_info_t m1_info_r;
  // multiply stage 2
  logic m2_v_r, m2_sign_r, m2_spec_r;
  logic [31:0] m2_p_r, m2_spec_bits_r, m2_bias_r;
  logic [7:0]  m2_e_r;
  logic signed [9:0] m2_sh_r;
  agd_pkg::lane_info_t m2_info_r;
  // product ready
  logic m3_v_r;
  logic [31:0] m3_pp_r, m3_bias_r;
  agd_pkg::lane_info_t m3_info_r;
  // add stages
  logic a1_v_r, a1_sign_r, a1_sub_r, a1_spec_r;
  logic [23:0] a1_mx_r, a1_my_r;
  logic [7:0]  a1_ex_r;
  logic [4:0]  a1_d_r;
  logic [31:0] a1_spec_bits_r;
  agd_pkg::lane_info_t a1_info_r;
  logic a2_v_r, a2_sign_r, a2_spec_r;
  logic [27:0] a2_sum_r;
  logic [7:0]  a2_ex_r;
  logic [31:0] a2_spec_bits_r;
  agd_pkg::lane_info_t a2_info_r;
  logic a3_v_r, a3_sign_r, a3_spec_r, a3_zero_r;
  logic [27:0] a3_sum_r;
  logic [7:0]  a3_ex_r;
  logic [4:0]  a3_l_r;
  logic [31:0] a3_spec_bits_r;
  agd_pkg::lane_info_t a3_info_r;
  // result
  logic        out_valid_r;
  logic [31:0] out_value_r;
  agd_pkg::lane_info_t out_info_r;

  assign adv = ~out_valid_r | ~out_stall;

  // ---- stage 1: significand times code
  logic [23:0] m1_m;
  logic [7:0]  m1_e;
  logic [31:0] m1_p;
  logic        m1_spec;
  logic [31:0] m1_spec_bits;
  always_comb begin
    m1_m = (lane.scale[30:23] == 8'd0) ? {1'b0, lane.scale[22:0]} : {1'b1, lane.scale[22:0]};
    m1_e = (lane.scale[30:23] == 8'd0) ? 8'd1 : lane.scale[30:23];
    m1_p = m1_m * {16'd0, lane.code};
    m1_spec      = 1'b1;
    m1_spec_bits = {lane.scale[31], 31'd0};
    if (lane.scale[30:23] == 8'hFF) begin
      if (lane.scale[22:0] != 23'd0) m1_spec_bits = lane.scale | agd_pkg::FP_QUIET_BIT;
      else if (lane.code == 8'd0)    m1_spec_bits = agd_pkg::FP_DEFAULT_NAN;
      else                           m1_spec_bits = {lane.scale[31], 8'hFF, 23'd0};
    end else if (m1_p == 32'd0) begin
      m1_spec_bits = {lane.scale[31], 31'd0};
    end else begin
      m1_spec = 1'b0;
    end
  end

  // ---- stage 2: leading one and shift amount
  logic [4:0]        m2_l;
  logic signed [9:0] m2_sha, m2_shb;
  always_comb begin
    m2_l   = agd_pkg::msb_index32(m1_p_r);
    m2_sha = $signed({5'd0, m2_l}) - 10'sd23;
    m2_shb = 10'sd1 - $signed({2'd0, m1_e_r});
  end

  // ---- stage 3: round product to fp32
  logic [3:0]  m3_rs;
  logic [31:0] m3_kept, m3_shl;
  logic        m3_g, m3_st;
  logic [9:0]  m3_neg;
  logic [4:0]  m3_ls;
  logic [24:0] m3_mr;
  logic signed [10:0] m3_er;
  logic signed [10:0] m3_field;
  logic [31:0] m3_pp;
  always_comb begin
    m3_rs   = m2_sh_r[3:0];
    m3_kept = m2_p_r >> m3_rs;
    m3_g    = (m3_rs != 4'd0) ? m2_p_r[5'(m3_rs - 4'd1)] : 1'b0;
    m3_st   = |(m2_p_r & ((32'd1 << 5'(m3_rs - 4'd1)) - 32'd1));
    m3_neg  = 10'(-m2_sh_r);
    m3_ls   = (|m3_neg[9:5]) ? 5'd31 : m3_neg[4:0];
    m3_shl  = m2_p_r << m3_ls;
    if (m2_sh_r > 10'sd0)
      m3_mr = {1'b0, m3_kept[23:0]} + {24'd0, m3_g & (m3_st | m3_kept[0])};
    else
      m3_mr = {1'b0, m3_shl[23:0]};
    m3_er = $signed({3'd0, m2_e_r}) + 11'(m2_sh_r);
    if (m3_mr[24])      m3_field = m3_er + 11'sd1;
    else if (m3_mr[23]) m3_field = m3_er;
    else                m3_field = 11'sd0;
    if (m3_field >= 11'sd255) m3_pp = {m2_sign_r, 8'hFF, 23'd0};
    else m3_pp = {m2_sign_r, m3_field[7:0], m3_mr[24] ? 23'd0 : m3_mr[22:0]};
    if (m2_spec_r) m3_pp = m2_spec_bits_r;
  end

  // ---- add stage 1: specials, order by magnitude
  logic [31:0] a1_a, a1_b, a1_big, a1_small, a1_spec_bits;
  logic        a1_anan, a1_bnan, a1_ainf, a1_binf, a1_spec;
  logic [7:0]  a1_ex, a1_ey, a1_d;
  always_comb begin
    a1_a    = m3_pp_r;
    a1_b    = m3_bias_r;
    a1_anan = (a1_a[30:23] == 8'hFF) && (a1_a[22:0] != 23'd0);
    a1_bnan = (a1_b[30:23] == 8'hFF) && (a1_b[22:0] != 23'd0);
    a1_ainf = (a1_a[30:23] == 8'hFF) && (a1_a[22:0] == 23'd0);
    a1_binf = (a1_b[30:23] == 8'hFF) && (a1_b[22:0] == 23'd0);
    a1_spec = 1'b1;
    if (a1_anan)                                     a1_spec_bits = a1_a | agd_pkg::FP_QUIET_BIT;
    else if (a1_bnan)                                a1_spec_bits = a1_b | agd_pkg::FP_QUIET_BIT;
    else if (a1_ainf && a1_binf && a1_a[31] != a1_b[31]) a1_spec_bits = agd_pkg::FP_DEFAULT_NAN;
    else if (a1_ainf)                                a1_spec_bits = a1_a;
    else if (a1_binf)                                a1_spec_bits = a1_b;
    else if (a1_a[30:0] == 31'd0 && a1_b[30:0] == 31'd0)
      a1_spec_bits = {a1_a[31] & a1_b[31], 31'd0};
    else begin
      a1_spec_bits = 32'd0;
      a1_spec      = 1'b0;
    end
    if (a1_a[30:0] >= a1_b[30:0]) begin
      a1_big   = a1_a;
      a1_small = a1_b;
    end else begin
      a1_big   = a1_b;
      a1_small = a1_a;
    end
    a1_ex = (a1_big[30:23] == 8'd0) ? 8'd1 : a1_big[30:23];
    a1_ey = (a1_small[30:23] == 8'd0) ? 8'd1 : a1_small[30:23];
    a1_d  = a1_ex - a1_ey;
  end

  // ---- add stage 2: align and add
  logic [26:0] a2_x3, a2_y3, a2_ysh;
  logic        a2_stk;
  logic [27:0] a2_sum;
  always_comb begin
    a2_x3  = {a1_mx_r, 3'd0};
    a2_y3  = {a1_my_r, 3'd0};
    a2_ysh = a2_y3 >> a1_d_r;
    a2_stk = |(a2_y3 & ((27'd1 << a1_d_r) - 27'd1));
    a2_ysh = {a2_ysh[26:1], a2_ysh[0] | a2_stk};
    a2_sum = a1_sub_r ? ({1'b0, a2_x3} - {1'b0, a2_ysh}) : ({1'b0, a2_x3} + {1'b0, a2_ysh});
  end

  // ---- add stage 4: normalize, round, pack
  logic [4:0]  a4_lz, a4_s;
  logic [7:0]  a4_lim;
  logic [26:0] a4_n;
  logic [8:0]  a4_er, a4_field;
  logic [24:0] a4_mr;
  logic [31:0] a4_res;
  always_comb begin
    a4_lz  = 5'd26 - a3_l_r;
    a4_lim = a3_ex_r - 8'd1;
    a4_s   = ({3'd0, a4_lz} < a4_lim) ? a4_lz : a4_lim[4:0];
    if (a3_sum_r[27]) begin
      a4_n  = {a3_sum_r[27:2], a3_sum_r[1] | a3_sum_r[0]};
      a4_er = {1'b0, a3_ex_r} + 9'd1;
    end else begin
      a4_n  = a3_sum_r[26:0] << a4_s;
      a4_er = {1'b0, a3_ex_r} - {4'd0, a4_s};
    end
    a4_mr = {1'b0, a4_n[26:3]} + {24'd0, a4_n[2] & (a4_n[1] | a4_n[0] | a4_n[3])};
    if (a4_mr[24])      a4_field = a4_er + 9'd1;
    else if (a4_mr[23]) a4_field = a4_er;
    else                a4_field = 9'd0;
    if (a4_field >= 9'd255) a4_res = {a3_sign_r, 8'hFF, 23'd0};
    else a4_res = {a3_sign_r, a4_field[7:0], a4_mr[24] ? 23'd0 : a4_mr[22:0]};
    if (a3_zero_r) a4_res = 32'd0;
    if (a3_spec_r) a4_res = a3_spec_bits_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p_r         <= m1_p;
      m1_e_r         <= m1_e;
      m1_sign_r      <= lane.scale[31];
      m1_spec_r      <= m1_spec;
      m1_spec_bits_r <= m1_spec_bits;
      m1_bias_r      <= lane.bias;
      m1_info_r      <= lane.info;

      m2_p_r         <= m1_p_r;
      m2_e_r         <= m1_e_r;
      m2_sign_r      <= m1_sign_r;
      m2_spec_r      <= m1_spec_r;
      m2_spec_bits_r <= m1_spec_bits_r;
      m2_bias_r      <= m1_bias_r;
      m2_info_r      <= m1_info_r;
      m2_sh_r        <= (m2_sha > m2_shb) ? m2_sha : m2_shb;

      m3_pp_r   <= m3_pp;
      m3_bias_r <= m2_bias_r;
      m3_info_r <= m2_info_r;

      a1_sign_r      <= a1_big[31];
      a1_sub_r       <= a1_a[31] ^ a1_b[31];
      a1_mx_r        <= {a1_big[30:23] != 8'd0, a1_big[22:0]};
      a1_my_r        <= {a1_small[30:23] != 8'd0, a1_small[22:0]};
      a1_ex_r        <= a1_ex;
      a1_d_r         <= (a1_d > 8'd27) ? 5'd28 : a1_d[4:0];
      a1_spec_r      <= a1_spec;
      a1_spec_bits_r <= a1_spec_bits;
      a1_info_r      <= m3_info_r;

      a2_sum_r       <= a2_sum;
      a2_ex_r        <= a1_ex_r;
      a2_sign_r      <= a1_sign_r;
      a2_spec_r      <= a1_spec_r;
      a2_spec_bits_r <= a1_spec_bits_r;
      a2_info_r      <= a1_info_r;

      a3_sum_r       <= a2_sum_r;
      a3_l_r         <= agd_pkg::msb_index32({4'd0, a2_sum_r});
      a3_zero_r      <= a2_sum_r == 28'd0;
      a3_ex_r        <= a2_ex_r;
      a3_sign_r      <= a2_sign_r;
      a3_spec_r      <= a2_spec_r;
      a3_spec_bits_r <= a2_spec_bits_r;
      a3_info_r      <= a2_info_r;

      out_value_r <= a4_res;
      out_info_r  <= a3_info_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      a1_v_r      <= 1'b0;
      a2_v_r      <= 1'b0;
      a3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m1_v_r      <= lane_valid;
      m2_v_r      <= m1_v_r;
      m3_v_r      <= m2_v_r;
      a1_v_r      <= m3_v_r;
      a2_v_r      <= a1_v_r;
      a3_v_r      <= a2_v_r;
      out_valid_r <= a3_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_info  = out_info_r;

endmodule

// ----- design/affine_group_dequantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_group_dequantizer
// Unpacks 4-bit or 8-bit codes and turns each into scale*code+bias in fp32.
// ----------------------------------------------------------------------------
// A packed word holds eight 4-bit codes or four 8-bit codes: the back end
// issues one code per cycle, unless a result stall holds it, into a shared
// fp32 multiply-add pipeline; a table write is done as it leaves the queue.
// A value passes the lane, multiply, product, add and result registers;
// a result stall holds the whole pipeline. After reset and after every
// register write a size check runs and input requests are stalled
// meanwhile. Table entries must be written before a row reads them.
module affine_group_dequantizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_packed_word,
  input  logic [7:0]  in_group_slot,
  input  logic [31:0] in_scale_bits,
  input  logic [31:0] in_bias_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value_bits,
  output logic [11:0] out_column,
  output logic        out_last_of_word,
  output logic        out_row_end,
  output logic        out_config_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  agd_pkg::cfg_t       cfg;
  agd_pkg::item_t      in_item;
  agd_pkg::item_t      q_item;
  agd_pkg::lane_t      lane;
  agd_pkg::lane_info_t out_info;
  logic                q_valid;
  logic                q_pop;
  logic                adv;
  logic                lane_valid;

  assign in_item.action      = in_action;
  assign in_item.packed_word = in_packed_word;
  assign in_item.group_slot  = in_group_slot;
  assign in_item.scale_bits  = in_scale_bits;
  assign in_item.bias_bits   = in_bias_bits;

  agd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  agd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .hold     (cfg.check_busy),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  agd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .adv        (adv),
    .lane_valid (lane_valid),
    .lane       (lane)
  );

  agd_fpu u_fpu (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (lane_valid),
    .lane       (lane),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value_bits),
    .out_info   (out_info)
  );

  assign out_column       = out_info.column;
  assign out_last_of_word = out_info.last_of_word;
  assign out_row_end      = out_info.row_end;
  assign out_config_error = out_info.config_error;

endmodule

// ----- dv/affine_group_dequantizer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_group_dequantizer_test
// Drives table writes and packed code words through the dequantizer under
// several register settings, and checks every fp32 value, column and flag
// against an independent fp32 multiply-add predictor.
// ----------------------------------------------------------------------------
module affine_group_dequantizer_test;

  typedef struct {
    logic [31:0] value_bits;
    logic [11:0] column;
    logic        last_of_word;
    logic        row_end;
    logic        config_error;
  } deq_value_t;

  class dequant_scoreboard;
    logic [31:0] scale_mem[agd_pkg::MAX_GROUPS];
    logic [31:0] bias_mem[agd_pkg::MAX_GROUPS];
    bit          slot_loaded[agd_pkg::MAX_GROUPS];
    int unsigned word_idx, col_idx, col_in_grp, grp_idx;
    logic        wide_codes;
    logic [12:0] grp_len;
    logic [9:0]  row_len;
    deq_value_t  pending_q[$];
    int          errors;

    function new();
      wide_codes = 1'b0;
      grp_len    = agd_pkg::GRP_LEN_RST;
      row_len    = agd_pkg::WORDS_PER_ROW_RST;
      errors     = 0;
      word_idx = 0; col_idx = 0; col_in_grp = 0; grp_idx = 0;
      foreach (slot_loaded[i]) slot_loaded[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        agd_pkg::REG_CODE_WIDTH_MODE: wide_codes = val[0];
        agd_pkg::REG_GRP_LEN:         grp_len    = val[12:0];
        agd_pkg::REG_WORDS_PER_ROW:   row_len    = val[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_row_len();
      if (row_len == 0) return 1;
      if (row_len > agd_pkg::MAX_WORDS_PER_ROW) return agd_pkg::MAX_WORDS_PER_ROW;
      return row_len;
    endfunction

    function int unsigned codes_per_word();
      return wide_codes ? 4 : 8;
    endfunction

    // first unloaded slot the next word would read, -1 when all are loaded
    function int missing_slot();
      int unsigned g, c, gs;
      g = grp_idx; c = col_in_grp;
      gs = (grp_len == 0) ? 1 : grp_len;
      for (int l = 0; l < codes_per_word(); l++) begin
        if (!slot_loaded[g]) return g;
        c++;
        if (c >= gs) begin
          c = 0;
          g = (g + 1) % agd_pkg::MAX_GROUPS;
        end
      end
      return -1;
    endfunction

    static function logic [31:0] fp_round(bit s, int e, bit [319:0] m);
      int p, sh, lsb;
      bit [319:0] sig, rem, half;
      longint enc;
      if (m == 0) return {s, 31'b0};
      p = 0;
      for (int i = 0; i < 320; i++) if (m[i]) p = i;
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh <= 0) sig = m << (-sh);
      else begin
        sig  = m >> sh;
        rem  = m & ((320'b1 << sh) - 1);
        half = 320'b1 << (sh - 1);
        if (rem > half || (rem == half && sig[0])) sig = sig + 1;
      end
      lsb = e + sh;
      enc = (longint'(lsb + 149) << 23) + longint'(sig[25:0]);
      if (enc >= 64'h7F80_0000) return {s, 8'hFF, 23'b0};
      return {s, enc[30:0]};
    endfunction

    static function logic [31:0] fp_mul_code(logic [31:0] a, logic [7:0] q);
      bit [319:0] m;
      int e;
      if (a[30:23] == 8'hFF) begin
        if (a[22:0] != 0) return a | agd_pkg::FP_QUIET_BIT;
        if (q == 0) return agd_pkg::FP_DEFAULT_NAN;
        return a;
      end
      if (q == 0 || a[30:0] == 0) return {a[31], 31'b0};
      m = (a[30:23] == 0) ? {297'b0, 1'b0, a[22:0]} : {297'b0, 1'b1, a[22:0]};
      e = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
      return fp_round(a[31], e, m * q);
    endfunction

    static function logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
      bit [319:0] mx, my, mag;
      int ex, ey, emn;
      bit s;
      if (x[30:23] == 8'hFF && x[22:0] != 0) return x | agd_pkg::FP_QUIET_BIT;
      if (y[30:23] == 8'hFF && y[22:0] != 0) return y | agd_pkg::FP_QUIET_BIT;
      if (x[30:23] == 8'hFF) begin
        if (y[30:23] == 8'hFF && x[31] != y[31]) return agd_pkg::FP_DEFAULT_NAN;
        return x;
      end
      if (y[30:23] == 8'hFF) return y;
      if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'b0};
      mx = (x[30:23] == 0) ? {297'b0, 1'b0, x[22:0]} : {297'b0, 1'b1, x[22:0]};
      my = (y[30:23] == 0) ? {297'b0, 1'b0, y[22:0]} : {297'b0, 1'b1, y[22:0]};
      ex = (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
      ey = (y[30:23] == 0) ? -149 : int'(y[30:23]) - 150;
      emn = (ex < ey) ? ex : ey;
      mx = mx << (ex - emn);
      my = my << (ey - emn);
      if (x[31] == y[31]) begin
        mag = mx + my; s = x[31];
      end else if (mx >= my) begin
        mag = mx - my; s = x[31];
      end else begin
        mag = my - mx; s = y[31];
      end
      if (mag == 0) return 32'b0;
      return fp_round(s, emn, mag);
    endfunction

    function void note_request(agd_pkg::item_t it);
      int unsigned n, cols, gs;
      logic [31:0] w;
      logic [7:0] q;
      bit err, last_w;
      deq_value_t v;
      if (it.action == agd_pkg::ACT_TABLE) begin
        scale_mem[it.group_slot] = it.scale_bits;
        bias_mem[it.group_slot]  = it.bias_bits;
        slot_loaded[it.group_slot] = 1;
        return;
      end
      n = codes_per_word();
      cols = eff_row_len() * n;
      err = (grp_len == 0) || (cols % grp_len != 0) ||
            (cols / grp_len > agd_pkg::MAX_GROUPS);
      gs = (grp_len == 0) ? 1 : grp_len;
      last_w = (word_idx + 1) >= eff_row_len();
      w = it.packed_word;
      for (int l = 0; l < n; l++) begin
        q = wide_codes ? w[7:0] : {4'b0, w[3:0]};
        v.value_bits   = fp_add(fp_mul_code(scale_mem[grp_idx], q), bias_mem[grp_idx]);
        v.column       = col_idx[11:0];
        v.last_of_word = (l == n - 1);
        v.row_end      = (l == n - 1) && last_w;
        v.config_error = err;
        pending_q.insert(pending_q.size(), v);
        w = wide_codes ? (w >> 8) : (w >> 4);
        col_idx++;
        col_in_grp++;
        if (col_in_grp >= gs) begin
          col_in_grp = 0;
          grp_idx = (grp_idx + 1) % agd_pkg::MAX_GROUPS;
        end
      end
      if (last_w) begin
        word_idx = 0; col_idx = 0; col_in_grp = 0; grp_idx = 0;
      end else word_idx++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_value(deq_value_t g);
      deq_value_t e;
      if (pending_q.size() == 0) begin
        report("unexpected value", g.value_bits, 32'b0);
        return;
      end
      e = pending_q.pop_front();
      if (g.value_bits !== e.value_bits) report("value_bits", g.value_bits, e.value_bits);
      if (g.column !== e.column) report("column", 32'(g.column), 32'(e.column));
      if (g.last_of_word !== e.last_of_word)
        report("last_of_word", 32'(g.last_of_word), 32'(e.last_of_word));
      if (g.row_end !== e.row_end) report("row_end", 32'(g.row_end), 32'(e.row_end));
      if (g.config_error !== e.config_error)
        report("config_error", 32'(g.config_error), 32'(e.config_error));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_stall, in_action;
  logic [31:0] in_packed_word, in_scale_bits, in_bias_bits;
  logic [7:0]  in_group_slot;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value_bits;
  logic [11:0] out_column;
  logic        out_last_of_word, out_row_end, out_config_error;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  dequant_scoreboard sb;
  bit idle_on;
  int sent_items;

  affine_group_dequantizer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_packed_word(in_packed_word), .in_group_slot(in_group_slot),
    .in_scale_bits(in_scale_bits), .in_bias_bits(in_bias_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_value_bits(out_value_bits),
    .out_column(out_column), .out_last_of_word(out_last_of_word),
    .out_row_end(out_row_end), .out_config_error(out_config_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    deq_value_t g;
    if (rst_n && out_valid && !out_stall) begin
      g.value_bits   = out_value_bits;
      g.column       = out_column;
      g.last_of_word = out_last_of_word;
      g.row_end      = out_row_end;
      g.config_error = out_config_error;
      sb.check_value(g);
    end
  end

  task automatic send_request(agd_pkg::item_t it);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= it.action;
    in_packed_word <= it.packed_word;
    in_group_slot  <= it.group_slot;
    in_scale_bits  <= it.scale_bits;
    in_bias_bits   <= it.bias_bits;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    sent_items++;
  endtask

  task automatic load_slot(logic [7:0] slot, logic [31:0] s, logic [31:0] b);
    agd_pkg::item_t it;
    it = '{action: agd_pkg::ACT_TABLE, packed_word: $urandom(), group_slot: slot,
           scale_bits: s, bias_bits: b};
    send_request(it);
  endtask

  function automatic logic [31:0] rand_fp();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
      2: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
      3: return {$urandom_range(0, 1) == 1, 8'hFE, 23'($urandom())};
      4: return {$urandom_range(0, 1) == 1, 31'b0};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 140)),
                       23'($urandom())};
    endcase
  endfunction

  // load any slot the next word reads, then send the word
  task automatic send_word(logic [31:0] w);
    agd_pkg::item_t it;
    int slot;
    slot = sb.missing_slot();
    while (slot >= 0) begin
      load_slot(slot[7:0], rand_fp(), rand_fp());
      slot = sb.missing_slot();
    end
    it = '{action: agd_pkg::ACT_WORD, packed_word: w, group_slot: 8'($urandom()),
           scale_bits: $urandom(), bias_bits: $urandom()};
    send_request(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(logic mode, logic [12:0] gs, logic [9:0] wpr);
    drain();
    apb_write(agd_pkg::REG_CODE_WIDTH_MODE, {31'b0, mode});
    apb_write(agd_pkg::REG_GRP_LEN, {19'b0, gs});
    apb_write(agd_pkg::REG_WORDS_PER_ROW, {22'b0, wpr});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) load_slot(8'($urandom()), rand_fp(), rand_fp());
      else send_word(rand_word());
    end
  endtask

  task automatic random_regs();
    logic mode;
    logic [9:0] wpr;
    logic [12:0] gs;
    int unsigned cols;
    mode = 1'($urandom_range(0, 1));
    wpr = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(1, 6)) : 10'($urandom());
    cols = ((wpr == 0) ? 1 : (wpr > 512 ? 512 : wpr)) * (mode ? 4 : 8);
    case ($urandom_range(0, 4))
      0: gs = 13'($urandom());
      1: gs = 13'($urandom_range(0, 9));
      default: gs = 13'(cols >> $urandom_range(0, 3));
    endcase
    set_regs(mode, gs, wpr);
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    sent_items = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_action = agd_pkg::ACT_TABLE; in_packed_word = '0;
    in_group_slot = '0; in_scale_bits = '0; in_bias_bits = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a couple of words at the reset settings
    load_slot(8'd0, 32'h3F80_0000, 32'h0);
    send_word(32'h7654_3210);
    send_word(32'hFEDC_BA98);

    // special floats: nan, infinities, signed zeros, subnormals, overflow
    set_regs(1'b0, 13'd4, 10'd4);
    load_slot(8'd0, 32'h3F80_0000, 32'h0000_0000);
    load_slot(8'd1, 32'h7F80_0000, 32'h0000_0000);
    load_slot(8'd2, 32'h7FA0_0001, 32'h3F80_0000);
    load_slot(8'd3, 32'h0000_0001, 32'h8000_0000);
    load_slot(8'd4, 32'h7F7F_FFFF, 32'hFF80_0000);
    load_slot(8'd5, 32'h8000_0000, 32'h0000_0000);
    load_slot(8'd6, 32'h3F80_0000, 32'h7FC1_2345);
    load_slot(8'd7, 32'h0080_0000, 32'h8080_0000);
    load_slot(8'hFF, 32'hBF80_0000, 32'h4000_0000);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7654_3210);
    send_word(32'hF0F0_0F0F);
    set_regs(1'b1, 13'd4, 10'd2);
    send_word(32'hFF00_80FF);
    send_word(32'h0180_7F01);

    set_regs(1'b1, 13'd4, 10'd3);   random_burst(20);
    idle_on = 1'b0;
    set_regs(1'b0, 13'd0, 10'd2);   random_burst(20);
    idle_on = 1'b1;
    set_regs(1'b1, 13'd3, 10'd2);   random_burst(10);
    // sender holds off until the pipeline has emptied
    drain();
    random_burst(10);
    set_regs(1'b0, 13'd1, 10'd0);   random_burst(12);
    set_regs(1'b1, 13'd4096, 10'd1023); random_burst(8);
    set_regs(1'b0, 13'h1FFF, 10'd512);  random_burst(6);
    set_regs(1'b0, 13'd16, 10'd512);    random_burst(6);
    set_regs(1'b1, 13'd1, 10'd1);   random_burst(12);

    while (sent_items < 360) begin
      random_regs();
      random_burst($urandom_range(15, 35));
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("affine_group_dequantizer_test OK");
    end else begin
      $display("affine_group_dequantizer_test NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("affine_group_dequantizer_test NOT OK");
    $finish;
  end

endmodule
